// ===== hw/rtl/csx_pkg.sv =====
// Shared types and constants for the ChaCha20 stream XOR core.
`timescale 1ns / 1ps
`default_nettype none
package csx_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RDA,
    S_RDC,
    S_CAP,
    S_STEP,
    S_WB,
    S_FF,
    S_KRD,
    S_KUSE,
    S_OUT
  } csx_state_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_MSG = 2'd1,
    STAT_WRAP   = 2'd2
  } csx_status_e;

  typedef enum logic [1:0] {
    RUN_IDLE    = 2'd0,
    RUN_ACTIVE  = 2'd1,
    RUN_STOPPED = 2'd2
  } csx_run_e;

  localparam logic [2:0] CFG_KEY_LOW      = 3'd0;
  localparam logic [2:0] CFG_KEY_MID_LOW  = 3'd1;
  localparam logic [2:0] CFG_KEY_MID_HIGH = 3'd2;
  localparam logic [2:0] CFG_KEY_HIGH     = 3'd3;
  localparam logic [2:0] CFG_NONCE_LOW    = 3'd4;
  localparam logic [2:0] CFG_NONCE_HIGH   = 3'd5;
  localparam logic [2:0] CFG_INIT_CTR     = 3'd6;

  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

endpackage
`default_nettype wire

// ===== hw/rtl/csx_if.sv =====
// Handshake channel interfaces for the ChaCha20 stream XOR core.
`timescale 1ns / 1ps
`default_nettype none
interface csx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface csx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink (input valid, input out_byte, input status, output ready);
endinterface

interface csx_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/chacha20_stream_xor_core.sv =====
// ChaCha20 (IETF, 96-bit nonce) keystream generator and byte XOR, top level.
//
// A byte with first set loads the block counter from initial_counter and builds
// a keystream block before its result. Each keystream block is built by one
// shared 32-bit add/xor/rotate unit working on a 16-word two-read-port state
// memory: the input words are loaded, each quarter round runs two reads,
// capture, four steps and four write-backs, and then the input words are added
// back. The result of a byte in a running message passes the keystream use
// state and then the output state, which waits until the output register is
// free. A byte that completes a 64-byte block adds one block build; a byte that
// starts a message adds one block build and a keystream read state. A byte sent
// before any start or after a wrap goes from acceptance straight to the output
// state. The input is not ready while a byte or block is in progress. A finished
// result sits in an output register, so the next byte can be taken while it
// waits.
`timescale 1ns / 1ps
`default_nettype none
module chacha20_stream_xor_core
  import csx_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  csx_in_if.sink         in_i,
  csx_out_if.source      out_o,
  csx_cfg_if.sink        cfg_i
);

  localparam int HalfRounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW       = $clog2(HalfRounds);

  // configuration
  logic [63:0] key_low_q, key_mid_low_q, key_mid_high_q, key_high_q, nonce_low_q;
  logic [31:0] nonce_high_q, init_ctr_q;

  // control
  csx_state_e  state_q, state_d;
  csx_run_e    run_q, run_d;
  logic [4:0]  widx_q, widx_d;
  logic [1:0]  step_q, step_d;
  logic [1:0]  qr_q, qr_d;
  logic [RndW-1:0] round_q, round_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] cnt_q, cnt_d;
  logic        gen_read_q, gen_read_d;
  logic        out_valid_q, out_valid_d;

  // payload
  logic [31:0] wa_q, wa_d, wb_q, wb_d, wc_q, wc_d, wd_q, wd_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  res_byte_q, res_byte_d;
  csx_status_e res_status_q, res_status_d;
  logic [7:0]  out_byte_q, out_byte_d;
  csx_status_e out_status_q, out_status_d;

  // working state memory
  logic [31:0] ww_mem [16];
  logic        mem_we;
  logic [3:0]  mem_waddr, ra0, ra1;
  logic [31:0] mem_wdata, rd0_q, rd1_q;

  logic        in_acc, out_free, last_round, wrap;
  logic [4:0]  widx_m1;
  logic [3:0]  init_idx;
  logic [31:0] init_word, op_p, op_q, op_z, sum, mix, rot, cnt_inc;
  logic [3:0]  addr_a, addr_b, addr_c, addr_d;
  logic [7:0]  ks_byte;

  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_round = (round_q == RndW'(HalfRounds - 1));
  assign widx_m1    = widx_q - 5'd1;
  assign cnt_inc    = cnt_q + 32'd1;
  assign wrap       = (pos_q == 6'd63) && (cnt_inc == init_ctr_q);
  assign ks_byte    = rd0_q[pos_q[1:0]*8 +: 8];

  assign in_i.ready     = (state_q == S_IDLE);
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.status   = out_status_q;

  // quarter-round word addresses, column or diagonal by half round
  always_comb begin
    addr_a = {2'b00, qr_q};
    addr_b = {2'b01, qr_q + {1'b0, round_q[0]}};
    addr_c = {2'b10, qr_q + {round_q[0], 1'b0}};
    addr_d = {2'b11, qr_q + {round_q[0], round_q[0]}};
  end

  // block input words
  assign init_idx = (state_q == S_FF) ? widx_m1[3:0] : widx_q[3:0];
  always_comb begin
    case (init_idx)
      4'd0:    init_word = SIGMA0;
      4'd1:    init_word = SIGMA1;
      4'd2:    init_word = SIGMA2;
      4'd3:    init_word = SIGMA3;
      4'd4:    init_word = key_low_q[31:0];
      4'd5:    init_word = key_low_q[63:32];
      4'd6:    init_word = key_mid_low_q[31:0];
      4'd7:    init_word = key_mid_low_q[63:32];
      4'd8:    init_word = key_mid_high_q[31:0];
      4'd9:    init_word = key_mid_high_q[63:32];
      4'd10:   init_word = key_high_q[31:0];
      4'd11:   init_word = key_high_q[63:32];
      4'd12:   init_word = cnt_q;
      4'd13:   init_word = nonce_low_q[31:0];
      4'd14:   init_word = nonce_low_q[63:32];
      default: init_word = nonce_high_q;
    endcase
  end

  // shared add / xor / rotate unit
  always_comb begin
    if (state_q == S_FF) begin
      op_p = rd0_q;
      op_q = init_word;
      op_z = '0;
    end else if (step_q[0]) begin
      op_p = wc_q;
      op_q = wd_q;
      op_z = wb_q;
    end else begin
      op_p = wa_q;
      op_q = wb_q;
      op_z = wd_q;
    end
    sum = op_p + op_q;
    mix = op_z ^ sum;
    case (step_q)
      2'd0:    rot = {mix[15:0], mix[31:16]};
      2'd1:    rot = {mix[19:0], mix[31:20]};
      2'd2:    rot = {mix[23:0], mix[31:24]};
      default: rot = {mix[24:0], mix[31:25]};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.first) state_d = S_INIT;
          else if (run_q == RUN_ACTIVE) state_d = S_KUSE;
          else state_d = S_OUT;
        end
      end
      S_INIT: if (widx_q[3:0] == 4'd15) state_d = S_RDA;
      S_RDA:  state_d = S_RDC;
      S_RDC:  state_d = S_CAP;
      S_CAP:  state_d = S_STEP;
      S_STEP: if (step_q == 2'd3) state_d = S_WB;
      S_WB: begin
        if (step_q == 2'd3) begin
          if (qr_q == 2'd3 && last_round) state_d = S_FF;
          else state_d = S_RDA;
        end
      end
      S_FF: begin
        if (widx_q == 5'd16) state_d = gen_read_q ? S_KRD : S_OUT;
      end
      S_KRD: state_d = S_KUSE;
      S_KUSE: begin
        if (pos_q == 6'd63 && !wrap) state_d = S_INIT;
        else state_d = S_OUT;
      end
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and sequencer outputs
  always_comb begin
    run_d        = run_q;
    widx_d       = widx_q;
    step_d       = step_q;
    qr_d         = qr_q;
    round_d      = round_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    gen_read_d   = gen_read_q;
    wa_d         = wa_q;
    wb_d         = wb_q;
    wc_d         = wc_q;
    wd_d         = wd_q;
    data_d       = data_q;
    res_byte_d   = res_byte_q;
    res_status_d = res_status_q;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    mem_we       = 1'b0;
    mem_waddr    = widx_q[3:0];
    mem_wdata    = init_word;
    ra0          = pos_q[5:2];
    ra1          = addr_b;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          data_d = in_i.data_byte;
          if (in_i.first) begin
            cnt_d      = init_ctr_q;
            pos_d      = '0;
            run_d      = RUN_ACTIVE;
            gen_read_d = 1'b1;
            widx_d     = '0;
          end else if (run_q == RUN_IDLE) begin
            res_byte_d   = '0;
            res_status_d = STAT_NO_MSG;
          end else if (run_q == RUN_STOPPED) begin
            res_byte_d   = '0;
            res_status_d = STAT_WRAP;
          end
        end
      end
      S_INIT: begin
        mem_we  = 1'b1;
        widx_d  = widx_q + 5'd1;
        round_d = '0;
        qr_d    = '0;
      end
      S_RDA: begin
        ra0 = addr_a;
        ra1 = addr_b;
      end
      S_RDC: begin
        wa_d = rd0_q;
        wb_d = rd1_q;
        ra0  = addr_c;
        ra1  = addr_d;
      end
      S_CAP: begin
        wc_d   = rd0_q;
        wd_d   = rd1_q;
        step_d = '0;
      end
      S_STEP: begin
        step_d = step_q + 2'd1;
        if (step_q[0]) begin
          wc_d = sum;
          wb_d = rot;
        end else begin
          wa_d = sum;
          wd_d = rot;
        end
      end
      S_WB: begin
        mem_we = 1'b1;
        step_d = step_q + 2'd1;
        case (step_q)
          2'd0: begin
            mem_waddr = addr_a;
            mem_wdata = wa_q;
          end
          2'd1: begin
            mem_waddr = addr_b;
            mem_wdata = wb_q;
          end
          2'd2: begin
            mem_waddr = addr_c;
            mem_wdata = wc_q;
          end
          default: begin
            mem_waddr = addr_d;
            mem_wdata = wd_q;
          end
        endcase
        if (step_q == 2'd3) begin
          qr_d = qr_q + 2'd1;
          if (qr_q == 2'd3) begin
            round_d = round_q + RndW'(1);
            widx_d  = '0;
          end
        end
      end
      S_FF: begin
        ra0       = widx_q[3:0];
        mem_we    = (widx_q != 5'd0);
        mem_waddr = widx_m1[3:0];
        mem_wdata = sum;
        widx_d    = widx_q + 5'd1;
      end
      S_KRD: begin
        ra0 = pos_q[5:2];
      end
      S_KUSE: begin
        pos_d        = pos_q + 6'd1;
        res_byte_d   = data_q ^ ks_byte;
        res_status_d = STAT_OK;
        if (pos_q == 6'd63) begin
          if (wrap) begin
            run_d        = RUN_STOPPED;
            res_byte_d   = '0;
            res_status_d = STAT_WRAP;
          end else begin
            cnt_d      = cnt_inc;
            gen_read_d = 1'b0;
            widx_d     = '0;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = res_byte_q;
          out_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= RUN_IDLE;
      widx_q      <= '0;
      step_q      <= '0;
      qr_q        <= '0;
      round_q     <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      gen_read_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      widx_q      <= widx_d;
      step_q      <= step_d;
      qr_q        <= qr_d;
      round_q     <= round_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      gen_read_q  <= gen_read_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q         <= wa_d;
    wb_q         <= wb_d;
    wc_q         <= wc_d;
    wd_q         <= wd_d;
    data_q       <= data_d;
    res_byte_q   <= res_byte_d;
    res_status_q <= res_status_d;
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q      <= '0;
      key_mid_low_q  <= '0;
      key_mid_high_q <= '0;
      key_high_q     <= '0;
      nonce_low_q    <= '0;
      nonce_high_q   <= '0;
      init_ctr_q     <= 32'd1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_KEY_LOW:      key_low_q      <= cfg_i.data;
        CFG_KEY_MID_LOW:  key_mid_low_q  <= cfg_i.data;
        CFG_KEY_MID_HIGH: key_mid_high_q <= cfg_i.data;
        CFG_KEY_HIGH:     key_high_q     <= cfg_i.data;
        CFG_NONCE_LOW:    nonce_low_q    <= cfg_i.data;
        CFG_NONCE_HIGH:   nonce_high_q   <= cfg_i.data[31:0];
        CFG_INIT_CTR:     init_ctr_q     <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ww_mem[mem_waddr] <= mem_wdata;
    rd0_q <= ww_mem[ra0];
    rd1_q <= ww_mem[ra1];
  end

endmodule
`default_nettype wire

// ===== tb/chacha20_stream_xor_core_tb.sv =====
// Self-checking testbench for chacha20_stream_xor_core with its own cipher predictor.
`timescale 1ns / 1ps
module chacha20_stream_xor_core_tb;
  import csx_pkg::*;

  localparam int NUM_DOUBLE_ROUNDS = 10;
  localparam int BLOCK_CYCLES = 33 + 88 * NUM_DOUBLE_ROUNDS;
  localparam int SETTLE_CYCLES = BLOCK_CYCLES + 100;
  localparam int ITEM_TARGET = 1050;
  localparam int MAX_REPORTS = 40;
  localparam longint TIMEOUT_NS = 64'd50_000_000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [2:0] REG_ORDER [7] = '{CFG_KEY_LOW, CFG_KEY_MID_LOW, CFG_KEY_MID_HIGH,
                                           CFG_KEY_HIGH, CFG_NONCE_LOW, CFG_NONCE_HIGH,
                                           CFG_INIT_CTR};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    csx_status_e status;
  } cipher_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = '0;
  logic        in_first = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  csx_in_if  in_ch ();
  csx_out_if out_ch ();
  csx_cfg_if cfg_ch ();

  assign in_ch.valid     = in_valid;
  assign in_ch.data_byte = in_data;
  assign in_ch.first     = in_first;
  assign out_ch.ready    = out_ready;
  assign cfg_ch.valid    = cfg_valid;
  assign cfg_ch.index    = cfg_index;
  assign cfg_ch.data     = cfg_data;

  chacha20_stream_xor_core #(
    .DOUBLE_ROUNDS(NUM_DOUBLE_ROUNDS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // register copies
  bit [63:0] key_lo = '0;
  bit [63:0] key_ml = '0;
  bit [63:0] key_mh = '0;
  bit [63:0] key_hi = '0;
  bit [63:0] nonce_lo = '0;
  bit [31:0] nonce_hi = '0;
  bit [31:0] ctr_init = 32'd1;

  // cipher state
  bit [7:0]  ks_bytes [64];
  bit [5:0]  ks_pos = '0;
  bit [31:0] blk_ctr = '0;
  csx_run_e  run_state = RUN_IDLE;

  byte_item_t     pending_q [$];
  cipher_result_t expected_q [$];

  int in_idle_pct = 33;
  int out_stall_pct = 88;
  int err_count = 0;
  int bytes_queued = 0;
  int msg_count = 0;
  int reg_writes = 0;
  int wrap_setups = 0;
  int results_seen = 0;
  int ok_count = 0;
  int no_msg_count = 0;
  int wrap_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic bit [31:0] rotl(input bit [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic bit [127:0] quarter_round(input bit [31:0] a_i, b_i, c_i, d_i);
    bit [31:0] a, b, c, d;
    a = a_i;
    b = b_i;
    c = c_i;
    d = d_i;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  function automatic void refill_keystream();
    bit [31:0] init_w [16];
    bit [31:0] w [16];
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[4]  = key_lo[31:0];
    init_w[5]  = key_lo[63:32];
    init_w[6]  = key_ml[31:0];
    init_w[7]  = key_ml[63:32];
    init_w[8]  = key_mh[31:0];
    init_w[9]  = key_mh[63:32];
    init_w[10] = key_hi[31:0];
    init_w[11] = key_hi[63:32];
    init_w[12] = blk_ctr;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
    w = init_w;
    for (int r = 0; r < NUM_DOUBLE_ROUNDS; r++) begin
      {w[0], w[4], w[8], w[12]}  = quarter_round(w[0], w[4], w[8], w[12]);
      {w[1], w[5], w[9], w[13]}  = quarter_round(w[1], w[5], w[9], w[13]);
      {w[2], w[6], w[10], w[14]} = quarter_round(w[2], w[6], w[10], w[14]);
      {w[3], w[7], w[11], w[15]} = quarter_round(w[3], w[7], w[11], w[15]);
      {w[0], w[5], w[10], w[15]} = quarter_round(w[0], w[5], w[10], w[15]);
      {w[1], w[6], w[11], w[12]} = quarter_round(w[1], w[6], w[11], w[12]);
      {w[2], w[7], w[8], w[13]}  = quarter_round(w[2], w[7], w[8], w[13]);
      {w[3], w[4], w[9], w[14]}  = quarter_round(w[3], w[4], w[9], w[14]);
    end
    for (int i = 0; i < 16; i++) begin
      w[i] = w[i] + init_w[i];
      for (int b = 0; b < 4; b++) begin
        ks_bytes[4 * i + b] = w[i][8 * b +: 8];
      end
    end
  endfunction

  function automatic cipher_result_t xor_next_byte(input byte_item_t item);
    cipher_result_t res;
    res.out_byte = '0;
    res.status   = STAT_OK;
    if (item.first) begin
      blk_ctr = ctr_init;
      refill_keystream();
      ks_pos = '0;
      run_state = RUN_ACTIVE;
    end
    if (run_state == RUN_IDLE) begin
      res.status = STAT_NO_MSG;
      return res;
    end
    if (run_state == RUN_STOPPED) begin
      res.status = STAT_WRAP;
      return res;
    end
    res.out_byte = item.data_byte ^ ks_bytes[ks_pos];
    ks_pos++;
    if (ks_pos == '0) begin
      blk_ctr++;
      if (blk_ctr == ctr_init) begin
        run_state = RUN_STOPPED;
        res.out_byte = '0;
        res.status = STAT_WRAP;
        return res;
      end
      refill_keystream();
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("%0t ERROR: %s", $time, what);
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    byte_item_t nxt;
    logic       accepted;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ch.ready;
      if (accepted) begin
        expected_q = {expected_q, xor_next_byte(byte_item_t'({in_data, in_first}))};
      end
      if (!in_valid || accepted) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt.data_byte;
          in_first <= nxt.first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    cipher_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ready) begin
        results_seen++;
        if (out_ch.status == STAT_OK) ok_count++;
        else if (out_ch.status == STAT_NO_MSG) no_msg_count++;
        else if (out_ch.status == STAT_WRAP) wrap_count++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result: byte %02h status %0d",
                                    out_ch.out_byte, out_ch.status));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("result %0d: out_byte %02h, expected %02h",
                                      results_seen, out_ch.out_byte, want.out_byte));
          end
          if (out_ch.status !== want.status) begin
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_seen, out_ch.status, want.status));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ch.ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KEY_LOW:      key_lo = value;
      CFG_KEY_MID_LOW:  key_ml = value;
      CFG_KEY_MID_HIGH: key_mh = value;
      CFG_KEY_HIGH:     key_hi = value;
      CFG_NONCE_LOW:    nonce_lo = value;
      CFG_NONCE_HIGH:   nonce_hi = value[31:0];
      CFG_INIT_CTR:     ctr_init = value[31:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // wait until every queued byte is sent and every expected result is checked, then settle
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic first);
    pending_q = {pending_q, byte_item_t'({data, first})};
    bytes_queued++;
    if (first) msg_count++;
  endtask

  task automatic queue_message(input int len);
    queue_byte(8'($urandom), 1'b1);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(59) == 0) queue_byte(8'($urandom), 1'($urandom));
      else queue_byte(8'($urandom), 1'b0);
    end
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int phase_no;
    int n;
    phase_no = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bytes before any start, then extremes, restarts mid-message, back-to-back starts
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFE, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hC3, 1'b1);
    queue_byte(8'h3C, 1'b1);
    queue_byte(8'hA5, 1'b0);
    wait_drained();

    while (bytes_queued < ITEM_TARGET) begin
      if (bytes_queued < ITEM_TARGET / 3) begin
        in_idle_pct = 33;
        out_stall_pct = 88;
      end else if (bytes_queued < 2 * ITEM_TARGET / 3) begin
        in_idle_pct = 88;
        out_stall_pct = 33;
      end else begin
        in_idle_pct = 0;
        out_stall_pct = 0;
      end

      if (phase_no == 0) begin
        for (int i = 0; i < $size(REG_ORDER); i++) write_reg(REG_ORDER[i], pick_value());
        write_reg(CFG_UNUSED, pick_value());
      end else begin
        case ($urandom_range(4))
          0: for (int i = 0; i < $size(REG_ORDER); i++) write_reg(REG_ORDER[i], '0);
          1: for (int i = 0; i < $size(REG_ORDER); i++) write_reg(REG_ORDER[i], '1);
          4: write_reg(CFG_UNUSED, pick_value());
          default: begin
            for (int i = 0; i < $size(REG_ORDER); i++) begin
              if ($urandom_range(1) == 0) write_reg(REG_ORDER[i], pick_value());
            end
          end
        endcase
      end

      if (run_state == RUN_ACTIVE && (phase_no == 1 || $urandom_range(3) == 0)) begin
        // arm a counter wrap at the end of the current block, then keep sending
        write_reg(CFG_INIT_CTR, {$urandom, blk_ctr + 32'd1});
        n = 64 - int'(ks_pos) + int'($urandom_range(6));
        repeat (n) queue_byte(8'($urandom), 1'b0);
        wrap_setups++;
      end else begin
        if (run_state != RUN_IDLE && $urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 20)) queue_byte(8'($urandom), 1'b0);
        end
        repeat ($urandom_range(1, 3)) begin
          if (bytes_queued < ITEM_TARGET) begin
            if ($urandom_range(3) == 0) queue_message(int'($urandom_range(65, 140)));
            else queue_message(int'($urandom_range(1, 40)));
          end
        end
      end
      wait_drained();
      phase_no++;
    end

    wait_drained();
    $display("Checked %0d results from %0d bytes in %0d messages:",
             results_seen, bytes_queued, msg_count);
    $display("  %0d ok, %0d unstarted, %0d wrapped; %0d register writes over %0d phases",
             ok_count, no_msg_count, wrap_count, reg_writes, phase_no);
    $display("  %0d counter wraps armed, %0d mismatches", wrap_setups, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
